@@ rtl/b64d_pkg.sv @@
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharPad     = 8'h3D;
  localparam logic [7:0] CharNewline = 8'h0A;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_NL   = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] sextet;
    logic       last;
  } item_t;

endpackage

@@ rtl/b64d_front.sv @@
`timescale 1ns / 1ps

module b64d_front (
  input  logic [7:0]     in_char_i,
  input  logic           in_last_i,
  output b64d_pkg::item_t item_o
);

  always_comb begin
    item_o.last   = in_last_i;
    item_o.sextet = 6'd0;
    item_o.kind   = b64d_pkg::KIND_BAD;
    case (in_char_i) inside
      [8'h41:8'h5A]: begin
        item_o.kind   = b64d_pkg::KIND_DATA;
        item_o.sextet = 6'(in_char_i - 8'h41);
      end
      [8'h61:8'h7A]: begin
        item_o.kind   = b64d_pkg::KIND_DATA;
        item_o.sextet = 6'(in_char_i - 8'h61 + 8'd26);
      end
      [8'h30:8'h39]: begin
        item_o.kind   = b64d_pkg::KIND_DATA;
        item_o.sextet = 6'(in_char_i - 8'h30 + 8'd52);
      end
      8'h2B: begin
        item_o.kind   = b64d_pkg::KIND_DATA;
        item_o.sextet = 6'd62;
      end
      8'h2F: begin
        item_o.kind   = b64d_pkg::KIND_DATA;
        item_o.sextet = 6'd63;
      end
      b64d_pkg::CharPad: begin
        item_o.kind = b64d_pkg::KIND_PAD;
      end
      b64d_pkg::CharNewline: begin
        item_o.kind = b64d_pkg::KIND_NL;
      end
      default: begin
        item_o.kind = b64d_pkg::KIND_BAD;
      end
    endcase
  end

endmodule

@@ rtl/b64d_queue.sv @@
`timescale 1ns / 1ps

module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64d_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output b64d_pkg::item_t head_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64d_pkg::item_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/b64d_back.sv @@
`timescale 1ns / 1ps

module b64d_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  b64d_pkg::item_t head_item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            msg_done_o,
  output logic            bad_input_o
);

  logic [1:0] pos_q, pos_d;
  logic [5:0] prev_q, prev_d;
  logic       pad_q, pad_d;
  logic       disc_q, disc_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q;
  logic       bv_q, done_q, bad_q;

  logic       err, bv, has_res;
  logic [7:0] byte_c;
  logic [1:0] pos_next;
  logic [5:0] v;

  assign v        = head_item_i.sextet;
  assign pos_next = pos_q + 2'd1;
  // the output register frees up when empty or when its transfer completes
  assign pop_o    = head_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    err     = 1'b0;
    bv      = 1'b0;
    byte_c  = 8'd0;
    has_res = 1'b0;
    pos_d   = pos_q;
    prev_d  = prev_q;
    pad_d   = pad_q;
    disc_d  = disc_q;

    if (disc_q) begin
      err = head_item_i.last;
    end else begin
      case (head_item_i.kind)
        b64d_pkg::KIND_NL: begin
          // newline is only skipped at a quartet boundary
          err = (pos_q != 2'd0);
        end
        b64d_pkg::KIND_PAD: begin
          if (pos_q == 2'd2) begin
            pad_d = 1'b1;
            pos_d = 2'd3;
            err   = head_item_i.last;
          end else if (pos_q == 2'd3) begin
            err   = !head_item_i.last;
            pos_d = 2'd0;
            pad_d = 1'b0;
          end else begin
            err = 1'b1;
          end
        end
        b64d_pkg::KIND_DATA: begin
          if (pad_q) begin
            err = 1'b1;
          end else begin
            case (pos_q)
              2'd1: begin
                bv     = 1'b1;
                byte_c = {prev_q, v[5:4]};
              end
              2'd2: begin
                bv     = 1'b1;
                byte_c = {prev_q[3:0], v[5:2]};
              end
              2'd3: begin
                bv     = 1'b1;
                byte_c = {prev_q[1:0], v};
              end
              default: begin
                bv = 1'b0;
              end
            endcase
            prev_d = v;
            pos_d  = pos_next;
            err    = head_item_i.last && (pos_next != 2'd0);
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end

    if (head_item_i.last) begin
      has_res = 1'b1;
      pos_d   = 2'd0;
      prev_d  = 6'd0;
      pad_d   = 1'b0;
      disc_d  = 1'b0;
    end else begin
      if (err) begin
        disc_d = 1'b1;
      end
      has_res = bv;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = has_res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      prev_q      <= 6'd0;
      pad_q       <= 1'b0;
      disc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        pos_q  <= pos_d;
        prev_q <= prev_d;
        pad_q  <= pad_d;
        disc_q <= disc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && has_res) begin
      byte_q <= bv ? byte_c : 8'd0;
      bv_q   <= bv;
      done_q <= head_item_i.last;
      bad_q  <= head_item_i.last && err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bv_q;
  assign msg_done_o   = done_q;
  assign bad_input_o  = bad_q;

endmodule

@@ rtl/base64_validating_decoder.sv @@
`timescale 1ns / 1ps

// base64 decoder with validation: one encoded character is taken per cycle while
// the queue is not full and at most one result leaves per cycle, so the sustained
// rate is one character per clock when the receiver does not stall; the decode
// state (quartet position, previous sextet, padding and error flags) updates in
// the back end as each character is popped. a character is classified on entry
// and written into a QueueDepth-entry queue, then the back end decodes it into an
// output register, so a character is held in the queue and then its result in the
// output register, which it leaves at an edge where out_stall_i is low. the input
// stalls only while the queue is full, and the queue drains whenever the output
// register is empty or its transfer completes. characters that yield no byte and
// do not end the message produce no transfer; the last character always produces
// one with msg_done_o set, and bad_input_o set if the message was malformed.
module base64_validating_decoder #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       msg_done_o,
  output logic       bad_input_o
);

  b64d_pkg::item_t in_item, head_item;
  logic            head_valid, pop, full;

  b64d_front u_front (
    .in_char_i (in_char_i),
    .in_last_i (in_last_i),
    .item_o    (in_item)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_item_i  (in_item),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  assign in_stall_o = full;

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .msg_done_o   (msg_done_o),
    .bad_input_o  (bad_input_o)
  );

endmodule

@@ verif/base64_validating_decoder_tb.sv @@
`timescale 1ns / 1ps

module base64_validating_decoder_tb;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam int unsigned NoSextet = 64;

  localparam int unsigned ItemsPerPhase = 160;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned DrainCycles   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       done;
    logic       bad;
  } decoded_t;

  // tracks the decode state of the block and the results it owes
  class decode_scoreboard;
    logic [1:0] quartet_pos;
    logic [5:0] prev_sextet;
    logic       pad_seen;
    logic       dropping;
    decoded_t   pending[$];
    int unsigned errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      quartet_pos = '0;
      prev_sextet = '0;
      pad_seen    = 1'b0;
      dropping    = 1'b0;
    endfunction

    function int unsigned sextet_of(logic [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 26;
      if (c >= "0" && c <= "9") return c - "0" + 52;
      if (c == CharPlus) return 62;
      if (c == CharSlash) return 63;
      return NoSextet;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // called for every accepted input transfer
    function void note_char(logic [7:0] c, logic last);
      logic        err;
      logic        bv;
      logic [7:0]  b;
      logic [1:0]  pos;
      int unsigned v;
      decoded_t    r;
      err = 1'b0;
      bv  = 1'b0;
      b   = '0;
      pos = quartet_pos;
      if (dropping) begin
        if (!last) return;
        err = 1'b1;
      end else if (pos == 2'd0 && c == b64d_pkg::CharNewline) begin
        // skipped at a quartet boundary
      end else if (c == b64d_pkg::CharPad) begin
        if (pos == 2'd2) begin
          pad_seen    = 1'b1;
          quartet_pos = 2'd3;
          if (last) err = 1'b1;
        end else if (pos == 2'd3) begin
          if (!last) err = 1'b1;
          quartet_pos = 2'd0;
          pad_seen    = 1'b0;
        end else begin
          err = 1'b1;
        end
      end else begin
        v = sextet_of(c);
        if (v == NoSextet || pad_seen) begin
          err = 1'b1;
        end else begin
          case (pos)
            2'd1: b = {prev_sextet, v[5:4]};
            2'd2: b = {prev_sextet[3:0], v[5:2]};
            2'd3: b = {prev_sextet[1:0], v[5:0]};
            default: b = '0;
          endcase
          bv          = (pos != 2'd0);
          prev_sextet = v[5:0];
          quartet_pos = pos + 2'd1;
          if (last && quartet_pos != 2'd0) err = 1'b1;
        end
      end
      if (last) begin
        r.data     = bv ? b : 8'h00;
        r.has_byte = bv;
        r.done     = 1'b1;
        r.bad      = err;
        pending.push_back(r);
        clear_state();
      end else begin
        if (err) dropping = 1'b1;
        if (bv) begin
          r.data     = b;
          r.has_byte = 1'b1;
          r.done     = 1'b0;
          r.bad      = 1'b0;
          pending.push_back(r);
        end
      end
    endfunction

    // called for every accepted output transfer
    task check_result(logic [7:0] b, logic bv, logic done, logic bad);
      decoded_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result byte=%02h bv=%b done=%b bad=%b", b, bv, done, bad));
        return;
      end
      e = pending.pop_front();
      if (bv !== e.has_byte || done !== e.done || bad !== e.bad ||
          (e.has_byte && b !== e.data)) begin
        report($sformatf("got byte=%02h bv=%b done=%b bad=%b, want byte=%02h bv=%b done=%b bad=%b",
                         b, bv, done, bad, e.data, e.has_byte, e.done, e.bad));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       msg_done;
  logic       bad_input;

  decode_scoreboard sb;
  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  int unsigned chars_sent;
  logic [7:0]  msg_chars[$];

  base64_validating_decoder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_char_i   (in_char),
    .in_last_i   (in_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .byte_valid_o(byte_valid),
    .msg_done_o  (msg_done),
    .bad_input_o (bad_input)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_byte, byte_valid, msg_done, bad_input);
    end
  end

  function automatic logic [7:0] char_of(int unsigned v);
    if (v < 26) return 8'(v) + "A";
    if (v < 52) return 8'(v - 26) + "a";
    if (v < 62) return 8'(v - 52) + "0";
    if (v == 62) return CharPlus;
    return CharSlash;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_chars.size(); i++) begin
      send_char(msg_chars[i], i == msg_chars.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    msg_chars.delete();
    for (int i = 0; i < s.len(); i++) msg_chars.push_back(s[i]);
    send_message();
  endtask

  // mostly well-formed messages with random content, the rest corrupted or noise
  task automatic build_random_message();
    int unsigned quads;
    int unsigned tail;
    int unsigned idx;
    int unsigned len;
    int unsigned sel;
    msg_chars.delete();
    sel = $urandom_range(0, 99);
    if (sel >= 90) begin
      len = $urandom_range(1, 8);
      repeat (len) msg_chars.push_back(8'($urandom_range(0, 255)));
      return;
    end
    quads = $urandom_range(0, 4);
    for (int q = 0; q < quads; q++) begin
      if (q != 0 && $urandom_range(0, 3) == 0) msg_chars.push_back(b64d_pkg::CharNewline);
      repeat (4) msg_chars.push_back(char_of($urandom_range(0, 63)));
    end
    tail = $urandom_range(0, 2);
    if (tail == 1) begin
      repeat (3) msg_chars.push_back(char_of($urandom_range(0, 63)));
      msg_chars.push_back(b64d_pkg::CharPad);
    end else if (tail == 2) begin
      repeat (2) msg_chars.push_back(char_of($urandom_range(0, 63)));
      msg_chars.push_back(b64d_pkg::CharPad);
      msg_chars.push_back(b64d_pkg::CharPad);
    end
    if (msg_chars.size() == 0 || (tail == 0 && $urandom_range(0, 3) == 0)) begin
      msg_chars.push_back(b64d_pkg::CharNewline);
    end
    if (sel >= 75) begin
      idx = $urandom_range(0, msg_chars.size() - 1);
      case ($urandom_range(0, 2))
        0: msg_chars[idx] = 8'($urandom_range(0, 255));
        1: msg_chars.insert(idx, $urandom_range(0, 1) ? b64d_pkg::CharPad
                                                      : b64d_pkg::CharNewline);
        default: begin
          len = $urandom_range(1, msg_chars.size());
          while (msg_chars.size() > len) void'(msg_chars.pop_back());
        end
      endcase
    end
  endtask

  initial begin
    sb         = new();
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 1'b0;
    chars_sent = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_char  <= '0;
    in_last  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // alphabet extremes, then a newline that ends the message
    send_text("+/Az\n");
    // double padding with unused low bits set
    send_text("QR==");
    // newline inside a quartet, then dropped until the last transfer
    send_text("QU\nI=");
    // padding at positions 0 and 1
    send_text("=");
    send_text("Q=");
    // message ends mid-quartet, byte still reported
    send_text("QUJ");
    // a further character after single padding, with a code from the upper half
    msg_chars.delete();
    msg_chars = '{"Q", "U", "I", b64d_pkg::CharPad, 8'hFF};
    send_message();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      if (phase == 0) hold_req = 1'b1;
      chars_sent = 0;
      while (chars_sent < ItemsPerPhase) begin
        build_random_message();
        send_message();
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64_validating_decoder.sv
verif/base64_validating_decoder_tb.sv
